>>> hdl/pic_pkg.sv
`default_nettype none
package pic_pkg;
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_LEVEL = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [25:0] addr;
        logic [63:0] wdata;
        logic [2:0]  size;
        logic [7:0]  strb;
        logic [9:0]  source_id;
        logic        level;
    } pic_in_t;

    typedef struct packed {
        logic [63:0] rdata;
        logic        meip;
        logic        seip;
    } pic_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture word, do direct access
        logic scan_clr;  // reset scan best
        logic scan_step; // evaluate one source
        logic finish;    // commit claim / irq and build result
    } pic_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic needs_scan;
        logic scan_last;
    } pic_sts_t;
endpackage
`default_nettype wire

>>> hdl/pic_if.sv
`default_nettype none
interface pic_in_if;
    import pic_pkg::*;
    logic    valid;
    logic    ready;
    pic_in_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pic_out_if;
    import pic_pkg::*;
    logic     valid;
    logic     ready;
    pic_out_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hdl/platform_interrupt_controller.sv
// Channel | Dir | Payload
// req     | in  | action, addr, wdata, size, strb, source_id, level
// rsp     | out | rdata, meip, seip
//
// Plain accesses: accepted in IDLE, then SCAN (no scan), DONE and OUT.
// Claim reads and ticks scan one source per cycle in the SCAN state,
// then pass through DONE to OUT.
// One word in flight; req is not ready until the result is taken.
// Reset clears the control state and the register file; rsp stalls hold the result.
`default_nettype none
module platform_interrupt_controller
    import pic_pkg::*;
#(
    parameter int NUM_SOURCES   = 32,
    parameter int NUM_CONTEXTS  = 2,
    parameter int PRIORITY_BITS = 3
)
(
    input wire logic clk,
    input wire logic rst_n,
    pic_in_if.sink   req,
    pic_out_if.source rsp
);
    pic_cmd_t cmd;
    pic_sts_t sts;

    pic_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    pic_dp #(
        .NUM_SOURCES   (NUM_SOURCES),
        .NUM_CONTEXTS  (NUM_CONTEXTS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (req.payload),
        .cmd      (cmd),
        .sts      (sts),
        .out_word (rsp.payload)
    );
endmodule
`default_nettype wire

>>> hdl/pic_ctrl.sv
`default_nettype none
module pic_ctrl
    import pic_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output pic_cmd_t      cmd,
    input  wire pic_sts_t sts
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.needs_scan)
                begin
                    cmd.scan_step = 1'b1;
                    if (sts.scan_last)
                        state_next = ST_DONE;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

>>> hdl/pic_dp.sv
`default_nettype none
module pic_dp
    import pic_pkg::*;
#(
    parameter int NUM_SOURCES   = 32,
    parameter int NUM_CONTEXTS  = 2,
    parameter int PRIORITY_BITS = 3
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire pic_in_t  in_word,
    input  wire pic_cmd_t cmd,
    output pic_sts_t      sts,
    output pic_out_t      out_word
);
    localparam int SW = $clog2(NUM_SOURCES);
    localparam int CW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int EN_BYTES = (NUM_SOURCES + 7) / 8;
    localparam int SRC_WORDS = (NUM_SOURCES + 31) / 32;
    localparam int PADS = EN_BYTES * 8;

    logic [PRIORITY_BITS-1:0] prio_reg [NUM_SOURCES];
    logic [PADS-1:0]          en_reg [NUM_CONTEXTS];
    logic [PRIORITY_BITS-1:0] thr_reg [NUM_CONTEXTS];
    logic [NUM_SOURCES-1:0]   asrt_reg, pend_reg, insv_reg;
    logic                     meip_reg, seip_reg;

    logic [63:0] rd_reg;
    logic [63:0] rdata_reg;
    logic        claim_reg, tick_reg;
    logic [CW-1:0] cctx_reg;
    logic [SW-1:0] idx_reg;
    // per-scan best for two contexts (claim uses slot 0)
    logic [SW-1:0]            best_reg [2];
    logic [PRIORITY_BITS-1:0] bestp_reg [2];

    // address decode of incoming word
    logic [25:0] a;
    logic [25:0] erel, crel;
    logic [19:0] ectx;
    logic [6:0]  eoff;
    logic [13:0] cctx;
    logic [11:0] coff;
    logic [23:0] pidx;
    logic [23:0] pw;
    logic        rd, wr;

    always_comb
    begin
        a    = in_word.addr;
        rd   = (in_word.action == ACT_READ);
        wr   = (in_word.action == ACT_WRITE);
        pidx = a[25:2];
        pw   = 24'(a[25:2] - 24'h400);
        erel = a - 26'h2000;
        ectx = erel[25:6] >> 1;
        eoff = erel[6:0];
        crel = a - 26'h200000;
        cctx = crel[25:12];
        coff = crel[11:0];
    end

    logic is_prio, is_pend, is_en, is_ctx, en_ok, ctx_ok;
    assign is_prio = (a < 26'h1000);
    assign is_pend = !is_prio && (a < 26'h2000);
    assign is_en   = !is_prio && !is_pend && (a < 26'h200000);
    assign is_ctx  = !is_prio && !is_pend && !is_en && (a < 26'h3FFF000);
    assign en_ok   = (32'(ectx) < NUM_CONTEXTS);
    assign ctx_ok  = (32'(cctx) < NUM_CONTEXTS);

    logic [63:0] direct_rd;
    always_comb
    begin
        logic [31:0] pwv;
        logic [9:0]  bi;
        direct_rd = '0;
        pwv = '0;
        bi = '0;
        if (is_prio)
        begin
            if (32'(pidx) < NUM_SOURCES)
                direct_rd = 64'(prio_reg[pidx[SW-1:0]]);
        end
        else if (is_pend)
        begin
            if (32'(pw) < SRC_WORDS)
            begin
                for (int b = 0; b < 32; b++)
                    if (32'(pw) * 32 + b < NUM_SOURCES)
                        pwv[b] = pend_reg[(32'(pw) * 32 + b) % NUM_SOURCES];
                direct_rd = 64'(pwv);
            end
        end
        else if (is_en)
        begin
            if (en_ok)
                for (int k = 0; k < 8; k++)
                    if (k <= int'(in_word.size) && 32'(eoff) + k < EN_BYTES)
                    begin
                        bi = 10'((32'(eoff) + k) % EN_BYTES);
                        direct_rd[k*8 +: 8] =
                            en_reg[ectx[CW-1:0]][bi*8 +: 8];
                    end
        end
        else if (is_ctx && ctx_ok && coff == 12'd0)
            direct_rd = 64'(thr_reg[cctx[CW-1:0]]);
    end

    // scan
    logic [PRIORITY_BITS-1:0] sp;
    logic [PRIORITY_BITS-1:0] thr_c [2];
    logic [SW-1:0]            ctx_of [2];
    always_comb
    begin
        sp = prio_reg[idx_reg];
        thr_c[0] = tick_reg ? thr_reg[0] : thr_reg[cctx_reg];
        thr_c[1] = thr_reg[(NUM_CONTEXTS > 1) ? 1 : 0];
        ctx_of[0] = '0;
        ctx_of[1] = '0;
    end

    logic hit [2];
    always_comb
    begin
        logic [CW-1:0] c0;
        c0 = tick_reg ? '0 : cctx_reg;
        hit[0] = pend_reg[idx_reg] && en_reg[c0][idx_reg] && sp != 0 &&
                 sp > thr_c[0] && sp > bestp_reg[0] && idx_reg != 0;
        hit[1] = pend_reg[idx_reg] && en_reg[CW'((NUM_CONTEXTS > 1) ? 1 : 0)][idx_reg] &&
                 sp != 0 && sp > thr_c[1] && sp > bestp_reg[1] && idx_reg != 0;
    end

    always_comb
    begin
        sts.needs_scan = claim_reg || tick_reg;
        sts.scan_last  = (32'(idx_reg) == NUM_SOURCES - 1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_reg <= rd ? direct_rd : '0;
            cctx_reg <= cctx[CW-1:0];
        end
        if (cmd.scan_clr)
            idx_reg <= '0;
        else if (cmd.scan_step && !sts.scan_last)
            idx_reg <= idx_reg + 1'b1;
        for (int c = 0; c < 2; c++)
        begin
            if (cmd.scan_clr)
            begin
                best_reg[c]  <= ctx_of[c];
                bestp_reg[c] <= '0;
            end
            else if (cmd.scan_step && hit[c])
            begin
                best_reg[c]  <= idx_reg;
                bestp_reg[c] <= sp;
            end
        end
        if (cmd.finish)
        begin
            rdata_reg <= claim_reg ? 64'(best_reg[0]) : rd_reg;
        end
    end

    always_comb
    begin
        out_word.rdata = rdata_reg;
        out_word.meip  = meip_reg;
        out_word.seip  = seip_reg;
    end

    logic [9:0] cid;
    assign cid = in_word.wdata[9:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
                prio_reg[i] <= '0;
            for (int c = 0; c < NUM_CONTEXTS; c++)
            begin
                en_reg[c]  <= '0;
                thr_reg[c] <= '0;
            end
            asrt_reg  <= '0;
            pend_reg  <= '0;
            insv_reg  <= '0;
            meip_reg  <= 1'b0;
            seip_reg  <= 1'b0;
            claim_reg <= 1'b0;
            tick_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                claim_reg <= rd && is_ctx && ctx_ok && coff == 12'd4;
                tick_reg  <= (in_word.action == ACT_TICK);
                if (in_word.action == ACT_TICK)
                    pend_reg <= pend_reg | (asrt_reg & ~insv_reg);
                if (in_word.action == ACT_LEVEL && in_word.source_id != 0 &&
                    32'(in_word.source_id) < NUM_SOURCES)
                    asrt_reg[in_word.source_id[SW-1:0]] <= in_word.level;
                if (wr)
                begin
                    if (is_prio && 32'(pidx) < NUM_SOURCES)
                        prio_reg[pidx[SW-1:0]] <= in_word.wdata[PRIORITY_BITS-1:0];
                    else if (is_en && en_ok)
                    begin
                        for (int k = 0; k < 8; k++)
                            if (k <= int'(in_word.size) && in_word.strb[k] &&
                                32'(eoff) + k < EN_BYTES)
                                en_reg[ectx[CW-1:0]][((32'(eoff) + k) % EN_BYTES) * 8 +: 8]
                                    <= in_word.wdata[k*8 +: 8];
                    end
                    else if (is_ctx && ctx_ok && coff == 12'd0)
                        thr_reg[cctx[CW-1:0]] <= in_word.wdata[PRIORITY_BITS-1:0];
                    else if (is_ctx && ctx_ok && coff == 12'd4 &&
                             in_word.wdata[15:10] == '0 && 32'(cid) < NUM_SOURCES)
                        insv_reg[cid[SW-1:0]] <= 1'b0;
                end
            end
            if (cmd.finish)
            begin
                if (claim_reg && best_reg[0] != 0)
                begin
                    pend_reg[best_reg[0]] <= 1'b0;
                    insv_reg[best_reg[0]] <= 1'b1;
                end
                if (tick_reg)
                begin
                    meip_reg <= (best_reg[0] != 0);
                    seip_reg <= (NUM_CONTEXTS > 1) && (best_reg[1] != 0);
                end
                claim_reg <= 1'b0;
                tick_reg  <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

>>> hdl/pic_checker.sv
`default_nettype none
module pic_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire logic [63:0] rsp_rdata
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready) else $error("accept while result held");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rdata))
        else $error("result dropped");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !rsp_valid) else $error("result too early");
endmodule

bind platform_interrupt_controller pic_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_rdata (rsp.payload.rdata)
);
`default_nettype wire
